[rtl/pid_pkg.sv]
// Shared types and constants of the PID controller with anti-windup clamp.
`default_nettype none

package pid_pkg;

	// Request operation codes
	localparam logic OP_STEP  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// Register file layout: register i at byte address 4*i
	localparam int unsigned PADDR_W   = 5;
	localparam int unsigned REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_P      = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_I      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_D      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_PWM_MAX     = 3'd4;

	localparam logic [14:0] DRIVE_LIMIT_RESET = 15'd255;
	localparam logic [7:0]  PWM_MAX_RESET     = 8'd255;

	// Integrator saturation bounds
	localparam logic signed [31:0] SUM_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SUM_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [15:0] gain_p;
		logic signed [15:0] gain_i;
		logic signed [15:0] gain_d;
		logic        [14:0] drive_limit;
		logic        [7:0]  pwm_max;
	} pid_cfg_t;

	typedef struct packed {
		logic        [7:0]  pwm_value;
		logic signed [15:0] drive_value;
		logic               limited;
	} pid_result_t;

endpackage

`default_nettype wire

[rtl/pid_ifs.sv]
// Request and result channel interfaces of the PID controller.
`default_nettype none

interface pid_req_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic                           operation;
	logic signed [SAMPLE_WIDTH-1:0] setpoint;
	logic signed [SAMPLE_WIDTH-1:0] measured;

	modport source (output valid, operation, setpoint, measured, input ready);
	modport sink (input valid, operation, setpoint, measured, output ready);
endinterface

interface pid_rsp_if;
	logic               valid;
	logic               ready;
	logic        [7:0]  pwm_value;
	logic signed [15:0] drive_value;
	logic               limited;

	modport source (output valid, pwm_value, drive_value, limited, input ready);
	modport sink (input valid, pwm_value, drive_value, limited, output ready);
endinterface

`default_nettype wire

[rtl/pid_cfg_regs.sv]
// APB register file holding the gains and the clamp limits.
`default_nettype none

module pid_cfg_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [pid_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	output pid_pkg::pid_cfg_t                cfg
);
	import pid_pkg::*;

	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;
	pid_cfg_t             cfg_q;

	assign pready = 1'b1;
	assign idx    = paddr[PADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p      <= '0;
			cfg_q.gain_i      <= '0;
			cfg_q.gain_d      <= '0;
			cfg_q.drive_limit <= DRIVE_LIMIT_RESET;
			cfg_q.pwm_max     <= PWM_MAX_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_GAIN_P:      cfg_q.gain_p      <= pwdata[15:0];
				REG_GAIN_I:      cfg_q.gain_i      <= pwdata[15:0];
				REG_GAIN_D:      cfg_q.gain_d      <= pwdata[15:0];
				REG_DRIVE_LIMIT: cfg_q.drive_limit <= pwdata[14:0];
				REG_PWM_MAX:     cfg_q.pwm_max     <= pwdata[7:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_GAIN_P:      prdata = {{16{cfg_q.gain_p[15]}}, cfg_q.gain_p};
			REG_GAIN_I:      prdata = {{16{cfg_q.gain_i[15]}}, cfg_q.gain_i};
			REG_GAIN_D:      prdata = {{16{cfg_q.gain_d[15]}}, cfg_q.gain_d};
			REG_DRIVE_LIMIT: prdata = {17'd0, cfg_q.drive_limit};
			REG_PWM_MAX:     prdata = {24'd0, cfg_q.pwm_max};
			default:         prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/pid_step.sv]
// One control step: error, saturating integrator, PID drive, clamp and PWM limit, or a clear of the state.
`default_nettype none

module pid_step #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           fire,
	input  wire logic                           operation,
	input  wire logic signed [SAMPLE_WIDTH-1:0] setpoint,
	input  wire logic signed [SAMPLE_WIDTH-1:0] measured,
	input  wire pid_pkg::pid_cfg_t              cfg,
	output pid_pkg::pid_result_t                result
);
	import pid_pkg::*;

	localparam int EW   = SAMPLE_WIDTH + 1;
	localparam int DFW  = SAMPLE_WIDTH + 2;
	localparam int SUMW = ((EW > 32) ? EW : 32) + 1;
	localparam int PPW  = 16 + EW;
	localparam int PIW  = 48;
	localparam int PDW  = 16 + DFW;
	localparam int PMW  = (PDW > PIW) ? PDW : PIW;
	localparam int DRW  = PMW - 8 + 2;

	function automatic logic signed [31:0] sat32(input logic signed [SUMW-1:0] v);
		logic signed [31:0] r;
		if (v > SUMW'(SUM_MAX))
			r = SUM_MAX;
		else if (v < SUMW'(SUM_MIN))
			r = SUM_MIN;
		else
			r = v[31:0];
		return r;
	endfunction

	logic signed [31:0]     sum_q;
	logic signed [EW-1:0]   last_q;
	logic signed [EW-1:0]   err;
	logic signed [DFW-1:0]  diff;
	logic signed [31:0]     sum_add;
	logic signed [31:0]     sum_back;
	logic signed [31:0]     sum_next;
	logic signed [PPW-1:0]  prod_p;
	logic signed [PIW-1:0]  prod_i;
	logic signed [PDW-1:0]  prod_d;
	logic signed [DRW-1:0]  drive_raw;
	logic signed [DRW-1:0]  lim_pos;
	logic signed [DRW-1:0]  lim_neg;
	logic signed [DRW-1:0]  drive_clamp;
	logic                   over_hi;
	logic                   over_lo;
	logic                   clamped;
	logic signed [15:0]     drive16;
	logic        [7:0]      pwm;
	logic                   is_clear;

	assign is_clear = (operation == OP_CLEAR);

	assign err     = EW'(setpoint) - EW'(measured);
	assign diff    = DFW'(err) - DFW'(last_q);
	assign sum_add = sat32(SUMW'(sum_q) + SUMW'(err));

	assign prod_p = PPW'(cfg.gain_p) * PPW'(err);
	assign prod_i = PIW'(cfg.gain_i) * PIW'(sum_add);
	assign prod_d = PDW'(cfg.gain_d) * PDW'(diff);

	// Arithmetic shift gives floor division by 256
	assign drive_raw = DRW'(prod_p >>> 8) + DRW'(prod_i >>> 8) + DRW'(prod_d >>> 8);

	assign lim_pos = DRW'($signed({1'b0, cfg.drive_limit}));
	assign lim_neg = -lim_pos;
	assign over_hi = drive_raw > lim_pos;
	assign over_lo = drive_raw < lim_neg;
	assign clamped = over_hi || over_lo;

	always_comb begin
		if (over_lo)
			drive_clamp = lim_neg;
		else if (over_hi)
			drive_clamp = lim_pos;
		else
			drive_clamp = drive_raw;
	end

	assign drive16  = drive_clamp[15:0];
	assign sum_back = sat32(SUMW'(sum_add) - SUMW'(err));
	assign sum_next = clamped ? sum_back : sum_add;

	always_comb begin
		if (drive16[15])
			pwm = '0;
		else if (drive16[14:0] > {7'd0, cfg.pwm_max})
			pwm = cfg.pwm_max;
		else
			pwm = drive16[7:0];
	end

	always_comb begin
		if (is_clear) begin
			result = '0;
		end else begin
			result.pwm_value   = pwm;
			result.drive_value = drive16;
			result.limited     = clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			last_q <= '0;
		end else if (fire) begin
			if (is_clear) begin
				sum_q  <= '0;
				last_q <= '0;
			end else begin
				sum_q  <= sum_next;
				last_q <= err;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/pid_controller_anti_windup.sv]
// Top level of the PID controller with anti-windup clamp.
`default_nettype none

// PID controller with anti-windup clamp. Each request carries a setpoint and
// a measured sample (operation step) or a clear command, and yields exactly one
// result. A step forms e = setpoint - measured, adds it to a 32-bit saturating
// error sum and computes floor(Kp*e/256) + floor(Ki*sum/256) +
// floor(Kd*(e - last_e)/256), gains in signed Q8.8. The drive is clamped to
// +-drive_limit; a clamp removes this step's error from the sum again and sets
// limited. pwm_value is the clamped drive bounded to 0..pwm_max. A clear zeroes
// the sum and the previous error and returns an all-zero result. A request
// passes one input register; then the whole step (three multipliers, the
// integrator and the clamp) is computed combinationally into the result
// register, which holds it until rsp.ready is seen. Throughput is one request
// per cycle while rsp.ready drains results; the error sum feedback lies within
// the single step, so it does not limit the rate. The user must write registers
// over APB (gain_p, gain_i, gain_d, drive_limit, pwm_max at byte addresses 0,
// 4, 8, 12, 16) only while no request is in flight; the block does not enforce it.
module pid_controller_anti_windup #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	pid_req_if.sink                          req,
	pid_rsp_if.source                        rsp,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [pid_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready
);
	import pid_pkg::*;

	pid_cfg_t    cfg;
	pid_result_t result;

	// Input stage
	logic                           valid_s1;
	logic                           operation_s1;
	logic signed [SAMPLE_WIDTH-1:0] setpoint_s1;
	logic signed [SAMPLE_WIDTH-1:0] measured_s1;

	// Result stage
	logic        valid_s2;
	pid_result_t result_s2;

	logic adv_s2;
	logic fire;
	logic take;

	// Advance the result stage when it is empty or being drained
	assign adv_s2    = !valid_s2 || rsp.ready;
	assign fire      = valid_s1 && adv_s2;
	assign req.ready = !valid_s1 || adv_s2;
	assign take      = req.valid && req.ready;

	pid_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pid_step #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.operation (operation_s1),
		.setpoint  (setpoint_s1),
		.measured  (measured_s1),
		.cfg       (cfg),
		.result    (result)
	);

	// Capture a request; drop the stage flag once its step has fired
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			operation_s1 <= req.operation;
			setpoint_s1  <= req.setpoint;
			measured_s1  <= req.measured;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= result;
		end
	end

	assign rsp.valid       = valid_s2;
	assign rsp.pwm_value   = result_s2.pwm_value;
	assign rsp.drive_value = result_s2.drive_value;
	assign rsp.limited     = result_s2.limited;

	// A clamped drive sits exactly on one of the two limits
	a_limited_on_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.limited |->
			(rsp.drive_value == $signed({1'b0, cfg.drive_limit})) ||
			(rsp.drive_value == -$signed({1'b0, cfg.drive_limit})))
		else $error("clamped drive off the limit");

	// The duty value never exceeds its upper bound
	a_pwm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.pwm_value <= cfg.pwm_max)
		else $error("pwm_value above pwm_max");

	// A negative drive gives zero duty
	a_pwm_negative: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.drive_value[15] |-> rsp.pwm_value == 8'd0)
		else $error("nonzero pwm_value for negative drive");

	// An unclamped drive stays within the limits
	a_unclamped_inside: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.limited |->
			(rsp.drive_value <= $signed({1'b0, cfg.drive_limit})) &&
			(rsp.drive_value >= -$signed({1'b0, cfg.drive_limit})))
		else $error("unclamped drive outside the limits");

endmodule

`default_nettype wire
